[src/fpas_pkg.sv]
package fpas_pkg;

    localparam int unsigned MaxExpGap = 25;

    // Command codes.
    localparam logic CmdAdd = 1'b0;
    localparam logic CmdSub = 1'b1;

    // Stage 1 to stage 2: aligned signed mantissas.
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_word;
        logic [7:0]  exp;
        logic [31:0] ma;
        logic [31:0] mb;
    } fpas_align_t;

    // Stage 2 to stage 3: magnitude of the sum.
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_word;
        logic [7:0]  exp;
        logic        sign;
        logic [31:0] mag;
    } fpas_sum_t;

    // Stage 3 to stage 4: normalized magnitude.
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_word;
        logic [7:0]  exp;
        logic        sign;
        logic [30:0] mag;
    } fpas_norm_t;

    // Position of the leading one in bits 31..0, returns 0 when none.
    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

[src/fpas_align.sv]
// First stage: special cases, operand unpack and exponent alignment.
module fpas_align (
    input  logic                  cmd,
    input  logic [31:0]           a,
    input  logic [31:0]           b_in,
    output fpas_pkg::fpas_align_t res
);
    logic [31:0] b;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [8:0]  dab;
    logic [8:0]  dba;

    always_comb begin
        b   = (cmd == fpas_pkg::CmdSub) ? {~b_in[31], b_in[30:0]} : b_in;
        ea  = a[30:23];
        eb  = b[30:23];
        ma  = {2'b00, 1'b1, a[22:0], 6'b0};
        mb  = {2'b00, 1'b1, b[22:0], 6'b0};
        if (a[31]) ma = 32'd0 - ma;
        if (b[31]) mb = 32'd0 - mb;
        dab = {1'b0, ea} - {1'b0, eb};
        dba = {1'b0, eb} - {1'b0, ea};

        res.bypass      = 1'b1;
        res.bypass_word = a;
        res.exp         = ea;
        res.ma          = ma;
        res.mb          = mb;
        // Zero operands: a zero second word, before or after the sign flip of a
        // subtract, returns a; a zero a returns +/-b.
        if (b_in == 32'd0 || b == 32'd0) begin
            res.bypass_word = a;
        end else if (a == 32'd0) begin
            res.bypass_word = b;
        end else if (ea > eb && dab > 9'(fpas_pkg::MaxExpGap)) begin
            res.bypass_word = a;
        end else if (eb > ea && dba > 9'(fpas_pkg::MaxExpGap)) begin
            res.bypass_word = b;
        end else begin
            res.bypass = 1'b0;
            if (ea > eb) begin
                res.mb = 32'($signed(mb) >>> dab[4:0]);
            end else begin
                res.ma  = 32'($signed(ma) >>> dba[4:0]);
                res.exp = eb;
            end
        end
    end
endmodule

[src/fpas_norm.sv]
// Third stage: shift the leading one to bit 29.
module fpas_norm (
    input  fpas_pkg::fpas_sum_t  s,
    output fpas_pkg::fpas_norm_t n
);
    logic [4:0]  pos;
    logic [31:0] m;
    logic [7:0]  e;

    always_comb begin
        pos = fpas_pkg::lead_one(s.mag);
        m   = s.mag;
        e   = s.exp;
        if (pos == 5'd31) begin
            m = s.mag >> 2;
            e = s.exp + 8'd2;
        end else if (pos == 5'd30) begin
            m = s.mag >> 1;
            e = s.exp + 8'd1;
        end else if (s.mag != 32'd0) begin
            m = s.mag << (5'd29 - pos);
            e = s.exp - 8'(5'd29 - pos);
        end
        n.bypass      = s.bypass;
        n.bypass_word = s.bypass_word;
        n.exp         = e;
        n.sign        = s.sign;
        n.mag         = m[30:0];
    end
endmodule

[src/fp32_add_subtract_core.sv]
// Pipelined single-precision add/subtract. Four register stages (align, add,
// normalize, round and pack); one word enters per cycle unless the output
// stalls, and its result is valid once it sits in the round and pack register; a
// stalled output holds the whole pipeline. Only an all-zero word counts as zero;
// infinity, NaN, subnormals and overflow are not treated specially and the
// exponent wraps modulo 256.
module fp32_add_subtract_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sum_bits
);
    logic [3:0]            vld_reg;
    logic [3:0]            vld_next;
    logic                  adv;
    fpas_pkg::fpas_align_t al;
    fpas_pkg::fpas_align_t al_reg;
    fpas_pkg::fpas_sum_t   sm;
    fpas_pkg::fpas_sum_t   sm_reg;
    fpas_pkg::fpas_norm_t  nm;
    fpas_pkg::fpas_norm_t  nm_reg;
    logic [31:0]           out_reg;
    logic [31:0]           out_next;
    logic [30:0]           rm;

    assign adv        = !vld_reg[3] || m_ready;
    assign s_ready    = adv;
    assign m_valid    = vld_reg[3];
    assign m_sum_bits = out_reg;
    assign vld_next   = {vld_reg[2:0], s_valid};

    fpas_align u_align (.cmd(s_command), .a(s_operand_a), .b_in(s_operand_b), .res(al));

    // Add the aligned mantissas and take the magnitude.
    always_comb begin
        logic [31:0] m;
        m = al_reg.ma + al_reg.mb;
        sm.bypass      = al_reg.bypass;
        sm.bypass_word = al_reg.bypass_word;
        sm.exp         = al_reg.exp;
        sm.sign        = m[31];
        sm.mag         = m[31] ? 32'd0 - m : m;
    end

    fpas_norm u_norm (.s(sm_reg), .n(nm));

    // Round, renormalize and pack.
    always_comb begin
        logic [7:0] e;
        rm = nm_reg.mag + (nm_reg.mag[6] ? 31'h20 : 31'h1F);
        e  = nm_reg.exp;
        if (rm[30]) begin
            rm = rm >> 1;
            e  = e + 8'd1;
        end
        if (nm_reg.bypass) begin
            out_next = nm_reg.bypass_word;
        end else if (nm_reg.mag == 31'd0) begin
            out_next = 32'd0;
        end else begin
            out_next = {nm_reg.sign, e, rm[28:6]};
        end
    end

    // Control: valid bits travel with the words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 4'd0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            al_reg  <= al;
            sm_reg  <= sm;
            nm_reg  <= nm;
            out_reg <= out_next;
        end
    end
endmodule
